FILE: src/m2mce_pkg.sv
// ----------------------------------------------------------------------------
// m2mce_pkg
// Shared function codes, status codes and the controller/datapath interface
// types for the memory-to-memory execute core.
// ----------------------------------------------------------------------------
`default_nettype none

package m2mce_pkg;

  localparam logic [4:0] F_SET   = 5'd0;
  localparam logic [4:0] F_CPY   = 5'd1;
  localparam logic [4:0] F_CPYI  = 5'd2;
  localparam logic [4:0] F_CPYI2 = 5'd3;
  localparam logic [4:0] F_ADD   = 5'd4;
  localparam logic [4:0] F_ADDI  = 5'd5;
  localparam logic [4:0] F_SUBI  = 5'd6;
  localparam logic [4:0] F_JIF   = 5'd7;
  localparam logic [4:0] F_PUSH  = 5'd8;
  localparam logic [4:0] F_POP   = 5'd9;
  localparam logic [4:0] F_CALL  = 5'd10;
  localparam logic [4:0] F_RET   = 5'd11;
  localparam logic [4:0] F_HLT   = 5'd12;
  localparam logic [4:0] F_USER  = 5'd13;
  localparam logic [4:0] F_SPRN  = 5'd14;
  localparam logic [4:0] F_SHLT  = 5'd15;
  localparam logic [4:0] F_SYLD  = 5'd16;
  localparam logic [4:0] F_LOAD  = 5'd17;
  localparam logic [4:0] F_READ  = 5'd18;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ADDR  = 3'd1;
  localparam logic [2:0] ST_IND   = 3'd2;
  localparam logic [2:0] ST_OVF   = 3'd3;
  localparam logic [2:0] ST_BADSP = 3'd4;
  localparam logic [2:0] ST_INVAL = 3'd5;

  typedef struct packed {
    logic       clr_step;
    logic       capture;
    logic       rd_issue;
    logic       rd_latch;
    logic       wr;
    logic       fin;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] n_rd;
    logic [1:0] n_wr;
    logic       err;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/m2mce_ram.sv
// ----------------------------------------------------------------------------
// m2mce_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module m2mce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/m2mce_ctrl.sv
// ----------------------------------------------------------------------------
// m2mce_ctrl
// Sequencer: clearing pass, operand reads, checks, writes and completion.
// ----------------------------------------------------------------------------
`default_nettype none

module m2mce_ctrl
  import m2mce_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_RL, S_CHK, S_WR, S_FIN} state_t;

  state_t     state_r;
  logic [1:0] k_r;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.k        = k_r;
    cmd.clr_step = (state_r == S_CLR);
    cmd.capture  = (state_r == S_IDLE) && in_valid;
    cmd.rd_issue = (state_r == S_RD) && (k_r != sts.n_rd);
    cmd.rd_latch = (state_r == S_RL);
    cmd.wr       = (state_r == S_WR);
    cmd.fin      = (state_r == S_FIN) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          if (sts.clr_last) state_r <= S_IDLE;
        end
        S_IDLE: begin
          k_r <= '0;
          if (in_valid) state_r <= S_RD;
        end
        S_RD: begin
          if (k_r == sts.n_rd) state_r <= S_CHK;
          else state_r <= S_RL;
        end
        S_RL: begin
          k_r     <= k_r + 2'd1;
          state_r <= S_RD;
        end
        S_CHK: begin
          k_r <= '0;
          if (sts.err || sts.n_wr == 2'd0) state_r <= S_FIN;
          else state_r <= S_WR;
        end
        S_WR: begin
          k_r <= k_r + 2'd1;
          if (k_r + 2'd1 == sts.n_wr) state_r <= S_FIN;
        end
        S_FIN: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_CLR;
      endcase
    end
  end

  a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> !sts.err) else $error("write issued for a failing instruction");
  a_fin_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> sts.out_free) else $error("completion without a free output slot");
  a_write_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |-> k_r < sts.n_wr) else $error("write index beyond plan");
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_RD && k_r == 2'd0) else $error("bad start");

endmodule

`default_nettype wire

FILE: src/m2mce_dpath.sv
// ----------------------------------------------------------------------------
// m2mce_dpath
// Datapath: word store, special words 0 to 3, operand registers, checks,
// write selection and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module m2mce_dpath
  import m2mce_pkg::*;
#(
  parameter int MEM_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [4:0]  in_func,
  input  wire logic [63:0] in_op_a,
  input  wire logic [63:0] in_op_b,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [63:0]      out_next_pc,
  output logic             out_print_valid,
  output logic [63:0]      out_print_value,
  output logic [63:0]      out_read_data,
  output logic             out_halted_flag,
  output logic             out_user_mode
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [63:0] LIM = 64'(MEM_WORDS);

  logic [4:0]    func_r;
  logic [63:0]   a_r, b_r, pc0_r, sp0_r, x_r, y_r, z_r;
  logic [63:0]   word_r [4];
  logic          halt_r, mode_r;
  logic [AW-1:0] clr_cnt_r, rd_idx_r;
  logic          out_valid_r;

  logic [63:0]   rd_addr, wr_addr, wr_data, rd_word, pc_inc;
  logic [AW-1:0] widx, ram_waddr;
  logic          ram_we, wr_low;
  logic [63:0]   ram_rdata;
  logic [2:0]    st;
  logic          ok, counted, halt_nxt, mode_nxt;
  logic [1:0]    n_rd, n_wr;

  function automatic logic rng(input logic [63:0] v);
    return v < LIM;
  endfunction

  assign pc_inc = pc0_r + 64'd1;

  always_comb begin
    rd_addr = a_r;
    unique case (func_r)
      F_POP, F_RET: rd_addr = sp0_r;
      F_CPYI:       rd_addr = (cmd.k == 2'd0) ? a_r : x_r;
      F_CPYI2:      rd_addr = (cmd.k == 2'd0) ? a_r : (cmd.k == 2'd1) ? b_r : x_r;
      F_ADDI, F_SUBI: rd_addr = (cmd.k == 2'd0) ? a_r : b_r;
      default:      rd_addr = a_r;
    endcase
  end

  always_comb begin
    unique case (func_r)
      F_CPY, F_ADD, F_JIF, F_POP, F_RET, F_SPRN, F_READ: n_rd = 2'd1;
      F_CPYI, F_ADDI, F_SUBI: n_rd = 2'd2;
      F_CPYI2: n_rd = 2'd3;
      default: n_rd = 2'd0;
    endcase
  end

  always_comb begin
    unique case (func_r)
      F_SET, F_CPY, F_CPYI, F_CPYI2, F_ADD, F_ADDI, F_SUBI, F_SPRN, F_LOAD: n_wr = 2'd1;
      F_JIF:          n_wr = (x_r == 64'd0 || x_r[63]) ? 2'd1 : 2'd0;
      F_PUSH, F_POP, F_RET: n_wr = 2'd2;
      F_CALL:         n_wr = 2'd3;
      default:        n_wr = 2'd0;
    endcase
  end

  always_comb begin
    wr_addr = b_r;
    wr_data = a_r;
    unique case (func_r)
      F_SET:   begin wr_addr = b_r; wr_data = a_r; end
      F_CPY:   begin wr_addr = b_r; wr_data = x_r; end
      F_CPYI:  begin wr_addr = b_r; wr_data = y_r; end
      F_CPYI2: begin wr_addr = y_r; wr_data = z_r; end
      F_ADD:   begin wr_addr = a_r; wr_data = x_r + b_r; end
      F_ADDI:  begin wr_addr = a_r; wr_data = x_r + y_r; end
      F_SUBI:  begin wr_addr = b_r; wr_data = x_r - y_r; end
      F_JIF:   begin wr_addr = 64'd0; wr_data = b_r; end
      F_PUSH: begin
        if (cmd.k == 2'd0) begin wr_addr = 64'd1; wr_data = sp0_r - 64'd1; end
        else begin wr_addr = sp0_r - 64'd1; wr_data = a_r; end
      end
      F_POP: begin
        if (cmd.k == 2'd0) begin wr_addr = 64'd1; wr_data = sp0_r + 64'd1; end
        else begin wr_addr = a_r; wr_data = x_r; end
      end
      F_RET: begin
        if (cmd.k == 2'd0) begin wr_addr = 64'd1; wr_data = sp0_r + 64'd1; end
        else begin wr_addr = 64'd0; wr_data = x_r; end
      end
      F_CALL: begin
        if (cmd.k == 2'd0) begin wr_addr = 64'd1; wr_data = sp0_r - 64'd1; end
        else if (cmd.k == 2'd1) begin wr_addr = sp0_r - 64'd1; wr_data = pc_inc; end
        else begin wr_addr = 64'd0; wr_data = a_r; end
      end
      F_SPRN:  begin wr_addr = 64'd2; wr_data = x_r; end
      F_LOAD:  begin wr_addr = a_r; wr_data = b_r; end
      default: begin wr_addr = b_r; wr_data = a_r; end
    endcase
  end

  always_comb begin
    st = ST_OK;
    unique case (func_r)
      F_SET: if (!rng(b_r)) st = ST_ADDR;
      F_CPY, F_ADDI, F_SUBI, F_JIF: if (!rng(a_r) || !rng(b_r)) st = ST_ADDR;
      F_CPYI: begin
        priority if (!rng(a_r) || !rng(b_r)) st = ST_ADDR;
        else if (!rng(x_r)) st = ST_IND;
      end
      F_CPYI2: begin
        priority if (!rng(a_r) || !rng(b_r)) st = ST_ADDR;
        else if (!rng(x_r) || !rng(y_r)) st = ST_IND;
      end
      F_ADD, F_SPRN, F_LOAD, F_READ: if (!rng(a_r)) st = ST_ADDR;
      F_PUSH: begin
        priority if (!rng(a_r)) st = ST_ADDR;
        else if (sp0_r == 64'd0 || sp0_r[63]) st = ST_OVF;
        else if (!rng(sp0_r)) st = ST_BADSP;
      end
      F_POP: begin
        priority if (!rng(a_r)) st = ST_ADDR;
        else if (!rng(sp0_r)) st = ST_BADSP;
      end
      F_CALL: begin
        priority if (!rng(a_r)) st = ST_ADDR;
        else if (sp0_r == 64'd0 || sp0_r[63]) st = ST_OVF;
        else if (!rng(pc_inc)) st = ST_ADDR;
        else if (!rng(sp0_r)) st = ST_BADSP;
      end
      F_RET: if (!rng(sp0_r)) st = ST_BADSP;
      F_HLT, F_USER, F_SHLT, F_SYLD: st = ST_OK;
      default: st = ST_INVAL;
    endcase
  end

  assign ok      = (st == ST_OK);
  assign counted = (func_r != F_LOAD) && (func_r != F_READ);

  always_comb begin
    halt_nxt = halt_r;
    mode_nxt = mode_r;
    if (ok) begin
      unique case (func_r)
        F_HLT:  halt_nxt = 1'b1;
        F_USER: mode_nxt = 1'b1;
        F_SPRN, F_SHLT, F_SYLD: mode_nxt = 1'b0;
        F_LOAD: begin halt_nxt = 1'b0; mode_nxt = 1'b0; end
        default: ;
      endcase
    end
  end

  assign widx      = wr_addr[AW-1:0];
  assign wr_low    = (widx < AW'(4));
  assign ram_we    = cmd.clr_step || (cmd.wr && !wr_low);
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : widx;
  assign rd_word   = (rd_idx_r < AW'(4)) ? word_r[rd_idx_r[1:0]] : ram_rdata;

  m2mce_ram #(.WIDTH(64), .DEPTH(MEM_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.clr_step ? 64'd0 : wr_data),
    .raddr (rd_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      halt_r      <= 1'b0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) word_r[i] <= 64'd0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.capture) begin
        func_r <= in_func;
        a_r    <= in_op_a;
        b_r    <= in_op_b;
        pc0_r  <= word_r[0];
        sp0_r  <= word_r[1];
      end
      if (cmd.rd_issue) rd_idx_r <= rd_addr[AW-1:0];
      if (cmd.rd_latch) begin
        unique case (cmd.k)
          2'd0:    x_r <= rd_word;
          2'd1:    y_r <= rd_word;
          default: z_r <= rd_word;
        endcase
      end
      if (cmd.wr && wr_low) word_r[widx[1:0]] <= wr_data;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.fin) begin
        if (ok && counted) begin
          word_r[3] <= word_r[3] + 64'd1;
          if (word_r[0] == pc0_r) word_r[0] <= pc_inc;
        end
        halt_r          <= halt_nxt;
        mode_r          <= mode_nxt;
        out_valid_r     <= 1'b1;
        out_status      <= st;
        out_next_pc     <= (ok && counted && word_r[0] == pc0_r) ? pc_inc : word_r[0];
        out_print_valid <= ok && (func_r == F_SPRN);
        out_print_value <= (ok && func_r == F_SPRN) ? x_r : 64'd0;
        out_read_data   <= (ok && func_r == F_READ) ? x_r : 64'd0;
        out_halted_flag <= halt_nxt;
        out_user_mode   <= mode_nxt;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.clr_last = (clr_cnt_r == AW'(MEM_WORDS - 1));
  assign sts.n_rd     = n_rd;
  assign sts.n_wr     = n_wr;
  assign sts.err      = !ok;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

FILE: src/memory_to_memory_cpu_execute_core.sv
// ----------------------------------------------------------------------------
// memory_to_memory_cpu_execute_core
// Executes one decoded instruction of a memory-to-memory machine per transfer.
//
// The input channel (in_valid/in_stall) carries func, op_a and op_b. The
// result channel (out_valid/out_stall) returns status, next_pc, the print
// word, the read word and the halt and mode flags for every instruction.
// Words 0 to 3 (PC, stack pointer, syscall result, instruction count) live in
// registers; all other words live in a RAM with one write and one registered
// read port. From transfer to result an instruction passes through a capture
// step, an issue and a latch step for each of its R dependent word reads (0
// to 3), a closing read step, a check step, one step for each of its W word
// writes (0 to 3, none when it fails) and a final step. One instruction is in
// flight at a time; the next input transfer is taken in the cycle after the
// previous result enters the output register.
// After reset the RAM is cleared one word per cycle with in_stall held high.
// A stalled result holds the block in its final step until the result
// transfer is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_to_memory_cpu_execute_core
  import m2mce_pkg::*;
#(
  parameter int MEM_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  in_func,
  input  wire logic [63:0] in_op_a,
  input  wire logic [63:0] in_op_b,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [63:0]      out_next_pc,
  output logic             out_print_valid,
  output logic [63:0]      out_print_value,
  output logic [63:0]      out_read_data,
  output logic             out_halted_flag,
  output logic             out_user_mode
);

  cmd_t cmd;
  sts_t sts;

  m2mce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  m2mce_dpath #(.MEM_WORDS(MEM_WORDS)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_op_a         (in_op_a),
    .in_op_b         (in_op_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_next_pc     (out_next_pc),
    .out_print_valid (out_print_valid),
    .out_print_value (out_print_value),
    .out_read_data   (out_read_data),
    .out_halted_flag (out_halted_flag),
    .out_user_mode   (out_user_mode)
  );

endmodule

`default_nettype wire

FILE: verif/m2mce_checker.sv
// ----------------------------------------------------------------------------
// m2mce_checker
// Watches both channels of the execute core. Each accepted instruction is run
// through a local model of the word store, halt flag and mode flag, and the
// predicted result is queued. Each result transfer is compared, field by
// field, with the oldest queued prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module m2mce_checker
  import m2mce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [4:0]  in_func,
  input  logic [63:0] in_op_a,
  input  logic [63:0] in_op_b,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [63:0] out_next_pc,
  input  logic        out_print_valid,
  input  logic [63:0] out_print_value,
  input  logic [63:0] out_read_data,
  input  logic        out_halted_flag,
  input  logic        out_user_mode,
  output int          errors,
  output int          pending
);

  localparam int WORDS = 1024;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] next_pc;
    logic        print_valid;
    logic [63:0] print_value;
    logic [63:0] read_data;
    logic        halted;
    logic        user;
  } exec_result_t;

  logic [63:0]  words [WORDS];
  logic         halted_q;
  logic         user_q;
  exec_result_t expected_results [$];

  function automatic logic addr_ok(logic [63:0] v);
    return v < 64'(WORDS);
  endfunction

  task automatic stack_push(input logic [63:0] value, output logic [2:0] st);
    logic [63:0] sp;
    sp = words[1];
    if (!addr_ok(value)) st = ST_ADDR;
    else if (sp == 0 || sp[63]) st = ST_OVF;
    else if (sp >= 64'(WORDS)) st = ST_BADSP;
    else begin
      sp = sp - 1;
      words[1] = sp;
      words[sp] = value;
      st = ST_OK;
    end
  endtask

  task automatic stack_pop(input logic [63:0] dest, output logic [2:0] st);
    logic [63:0] sp;
    logic [63:0] v;
    sp = words[1];
    if (!addr_ok(dest)) st = ST_ADDR;
    else if (!addr_ok(sp)) st = ST_BADSP;
    else begin
      v = words[sp];
      words[1] = sp + 1;
      words[dest] = v;
      st = ST_OK;
    end
  endtask

  task automatic execute_instr(input logic [4:0] f, input logic [63:0] a,
                               input logic [63:0] b, output exec_result_t r);
    logic [63:0] pc;
    logic [2:0]  st;
    logic        counted;
    pc = words[0];
    st = ST_OK;
    counted = 1'b1;
    r.print_valid = 1'b0;
    r.print_value = '0;
    r.read_data = '0;
    case (f)
      F_SET: begin
        if (!addr_ok(b)) st = ST_ADDR;
        else words[b] = a;
      end
      F_CPY: begin
        if (!addr_ok(a) || !addr_ok(b)) st = ST_ADDR;
        else words[b] = words[a];
      end
      F_CPYI: begin
        if (!addr_ok(a) || !addr_ok(b)) st = ST_ADDR;
        else if (!addr_ok(words[a])) st = ST_IND;
        else words[b] = words[words[a]];
      end
      F_CPYI2: begin
        if (!addr_ok(a) || !addr_ok(b)) st = ST_ADDR;
        else if (!addr_ok(words[a]) || !addr_ok(words[b])) st = ST_IND;
        else words[words[b]] = words[words[a]];
      end
      F_ADD: begin
        if (!addr_ok(a)) st = ST_ADDR;
        else words[a] = words[a] + b;
      end
      F_ADDI: begin
        if (!addr_ok(a) || !addr_ok(b)) st = ST_ADDR;
        else words[a] = words[a] + words[b];
      end
      F_SUBI: begin
        if (!addr_ok(a) || !addr_ok(b)) st = ST_ADDR;
        else words[b] = words[a] - words[b];
      end
      F_JIF: begin
        if (!addr_ok(a) || !addr_ok(b)) st = ST_ADDR;
        else if (words[a] == 0 || words[a][63]) words[0] = b;
      end
      F_PUSH: stack_push(a, st);
      F_POP:  stack_pop(a, st);
      F_CALL: begin
        if (!addr_ok(a)) st = ST_ADDR;
        else if (words[1] == 0 || words[1][63]) st = ST_OVF;
        else begin
          stack_push(pc + 1, st);
          if (st == ST_OK) words[0] = a;
        end
      end
      F_RET:  stack_pop(64'd0, st);
      F_HLT:  halted_q = 1'b1;
      F_USER: user_q = 1'b1;
      F_SPRN: begin
        if (!addr_ok(a)) st = ST_ADDR;
        else begin
          user_q = 1'b0;
          r.print_valid = 1'b1;
          r.print_value = words[a];
          words[2] = words[a];
        end
      end
      F_SHLT, F_SYLD: user_q = 1'b0;
      F_LOAD: begin
        counted = 1'b0;
        if (!addr_ok(a)) st = ST_ADDR;
        else begin
          words[a] = b;
          halted_q = 1'b0;
          user_q = 1'b0;
        end
      end
      F_READ: begin
        counted = 1'b0;
        if (!addr_ok(a)) st = ST_ADDR;
        else r.read_data = words[a];
      end
      default: st = ST_INVAL;
    endcase
    if (st == ST_OK && counted) begin
      words[3] = words[3] + 1;
      if (words[0] == pc) words[0] = pc + 1;
    end
    r.status = st;
    r.next_pc = words[0];
    r.halted = halted_q;
    r.user = user_q;
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    exec_result_t r;
    if (!rst_n) begin
      foreach (words[i]) words[i] = '0;
      halted_q = 1'b0;
      user_q = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no instruction outstanding");
          errors++;
        end else begin
          r = expected_results.pop_front();
          compare_field("status", r.status, out_status);
          compare_field("next_pc", r.next_pc, out_next_pc);
          compare_field("print_valid", r.print_valid, out_print_valid);
          compare_field("print_value", r.print_value, out_print_value);
          compare_field("read_data", r.read_data, out_read_data);
          compare_field("halted_flag", r.halted, out_halted_flag);
          compare_field("user_mode", r.user, out_user_mode);
        end
      end
      if (in_valid && !in_stall) begin
        execute_instr(in_func, in_op_a, in_op_b, r);
        expected_results = {expected_results, r};
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives decoded instructions into the execute core under several patterns of
// sender gaps and receiver stalls, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import m2mce_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  in_func = '0;
  logic [63:0] in_op_a = '0;
  logic [63:0] in_op_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [63:0] out_next_pc;
  logic        out_print_valid;
  logic [63:0] out_print_value;
  logic [63:0] out_read_data;
  logic        out_halted_flag;
  logic        out_user_mode;
  int          errors;
  int          pending;
  int          gap_pct = 0;
  int          stall_pct = 0;

  always #2 clk = ~clk;

  memory_to_memory_cpu_execute_core u_dut (.*);

  m2mce_checker u_checker (.*);

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send_instr(input logic [4:0] f, input logic [63:0] a,
                            input logic [63:0] b);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_op_a <= a;
    in_op_b <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_addr();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return 64'($urandom_range(15));
    if (p < 88) return 64'($urandom_range(1023));
    if (p < 94) return 64'd1024 + 64'($urandom_range(3));
    return rand_word();
  endfunction

  function automatic logic [63:0] rand_data();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 64'($urandom_range(15));
    if (p < 75) return 64'($urandom_range(1023));
    if (p < 85) return -64'($urandom_range(3));
    return rand_word();
  endfunction

  task automatic random_instr();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 8) send_instr(F_LOAD, 64'd1, 64'($urandom_range(4, 1023)));
    else if (p < 30) send_instr(F_LOAD, rand_addr(), rand_data());
    else if (p < 36) send_instr(F_READ, rand_addr(), rand_word());
    else if (p < 40) send_instr(5'($urandom_range(19, 31)), rand_word(), rand_word());
    else send_instr(5'($urandom_range(F_SYLD)), rand_data() < 1024 ? rand_addr()
                    : rand_data(), rand_addr());
  endtask

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_instr(F_READ, 64'd3, 64'd0);
    send_instr(F_CALL, 64'd20, 64'd0);
    send_instr(F_PUSH, 64'd5, 64'd0);
    send_instr(F_RET, 64'd0, 64'd0);
    send_instr(F_LOAD, 64'd1, 64'h8000_0000_0000_0000);
    send_instr(F_POP, 64'd4, 64'd0);
    send_instr(F_CALL, 64'd20, 64'd0);
    send_instr(F_LOAD, 64'd1, 64'd1024);
    send_instr(F_PUSH, 64'd6, 64'd0);
    send_instr(F_LOAD, 64'd1, 64'd1000);
    send_instr(F_SET, 64'h7fff_ffff_ffff_ffff, 64'd8);
    send_instr(F_ADD, 64'd8, 64'd1);
    send_instr(F_SET, 64'd2000, 64'd9);
    send_instr(F_CPYI, 64'd9, 64'd10);
    send_instr(F_CPYI2, 64'd12, 64'd11);
    send_instr(F_CPY, 64'd8, 64'hffff_ffff_ffff_ffff);
    send_instr(F_ADDI, 64'd8, 64'd8);
    send_instr(F_SUBI, 64'd8, 64'd13);
    send_instr(F_LOAD, 64'd0, 64'd50);
    send_instr(F_JIF, 64'd14, 64'd50);
    send_instr(F_CALL, 64'd30, 64'd0);
    send_instr(F_PUSH, 64'd1, 64'd0);
    send_instr(F_POP, 64'd1, 64'd0);
    send_instr(F_HLT, 64'd0, 64'd0);
    send_instr(F_USER, 64'd0, 64'd0);
    send_instr(F_SPRN, 64'd1024, 64'd0);
    send_instr(F_SPRN, 64'd8, 64'd0);
    send_instr(F_USER, 64'd0, 64'd0);
    send_instr(F_SHLT, 64'd0, 64'd0);
    send_instr(F_SYLD, 64'd0, 64'd0);
    send_instr(5'd31, 64'd0, 64'd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 66; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 66; end
        default: begin gap_pct = 11; stall_pct = 11; end
      endcase
      repeat (300) random_instr();
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
